/* src/gfr_pkg.sv */
// ----------------------------------------------------------------------------
// gfr_pkg
// Shared types, constants and the byte-wise CRC-16 step for the GDL90 frame
// receiver.
// ----------------------------------------------------------------------------
package gfr_pkg;

  // framing bytes
  localparam logic [7:0]  FLAG_BYTE  = 8'h7E;
  localparam logic [7:0]  ESC_BYTE   = 8'h7D;
  localparam logic [7:0]  ESC_XOR    = 8'h20;
  localparam logic [15:0] CRC_POLY   = 16'h1021;
  localparam logic [7:0]  OWNSHIP_ID = 8'd10;

  // frame status codes
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_START  = 3'd1,
    ST_BAD_END    = 3'd2,
    ST_TOO_SHORT  = 3'd3,
    ST_DANGLE_ESC = 3'd4,
    ST_CRC_ERR    = 3'd5
  } gfr_status_t;

  // one input beat
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } gfr_beat_t;

  // one result item
  typedef struct packed {
    gfr_status_t        status;
    logic [7:0]         message_id;
    logic [9:0]         payload_length;
    logic [15:0]        crc_computed;
    logic [15:0]        crc_received;
    logic               is_heartbeat;
    logic               position_valid;
    logic               ownship_length_ok;
    logic signed [23:0] latitude_raw;
    logic signed [23:0] longitude_raw;
  } gfr_result_t;

  // crc-16 step, byte enters at the low end (augmented form)
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] t;
    t = {crc[15:8], 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (t[15]) begin
        t = {t[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        t = {t[14:0], 1'b0};
      end
    end
    return t ^ {crc[7:0], 8'h00} ^ {8'h00, b};
  endfunction

endpackage

/* src/gfr_if.sv */
// ----------------------------------------------------------------------------
// gfr channel interfaces
// Valid/ready channels for input bytes, results and the configuration write.
// ----------------------------------------------------------------------------
interface gfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface gfr_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [7:0]         message_id;
  logic [9:0]         payload_length;
  logic [15:0]        crc_computed;
  logic [15:0]        crc_received;
  logic               is_heartbeat;
  logic               position_valid;
  logic               ownship_length_ok;
  logic signed [23:0] latitude_raw;
  logic signed [23:0] longitude_raw;

  modport source (output valid, output status, output message_id, output payload_length,
                  output crc_computed, output crc_received, output is_heartbeat,
                  output position_valid, output ownship_length_ok,
                  output latitude_raw, output longitude_raw, input ready);
  modport sink   (input valid, input status, input message_id, input payload_length,
                  input crc_computed, input crc_received, input is_heartbeat,
                  input position_valid, input ownship_length_ok,
                  input latitude_raw, input longitude_raw, output ready);
endinterface

interface gfr_cfg_if;
  logic valid;
  logic ready;
  logic crc_check_enable;

  modport source (output valid, output crc_check_enable, input ready);
  modport sink   (input valid, input crc_check_enable, output ready);
endinterface

/* src/gfr_frame_core.sv */
// ----------------------------------------------------------------------------
// gfr_frame_core
// Per-frame state: flag check, de-escaping, crc hold-back, field capture and
// the end-of-frame result built from that state and the closing byte.
// ----------------------------------------------------------------------------
module gfr_frame_core #(
  parameter int MAX_FRAME_BYTES = 512
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  gfr_pkg::gfr_beat_t beat,
  input  logic               crc_check_enable,
  output gfr_pkg::gfr_result_t result
);
  import gfr_pkg::*;

  localparam int DCW = $clog2(MAX_FRAME_BYTES + 3);
  localparam logic [DCW-1:0] DEC_SAT = DCW'(MAX_FRAME_BYTES + 2);
  localparam logic [2:0] RAW_SAT = 3'd5;
  localparam logic signed [23:0] LAT_LIMIT = 24'sd4194304;

  logic [2:0]     raw_cnt_r, raw_cnt_nxt;
  logic           start_seen_r, start_seen_nxt;
  logic           esc_r, esc_nxt;
  logic [DCW-1:0] dec_cnt_r, dec_cnt_nxt;
  logic [15:0]    crc_r, crc_nxt;
  logic [7:0]     older_r, older_nxt;
  logic [7:0]     newer_r, newer_nxt;
  logic [7:0]     type_r, type_nxt;
  logic [23:0]    lat_r, lat_nxt;
  logic [23:0]    lon_r, lon_nxt;

  logic           first;
  logic [2:0]     raw_inc;
  logic [7:0]     dec_byte;
  logic [DCW-1:0] plen;
  logic [15:0]    rx_crc;
  logic           start_ok;
  logic signed [23:0] lat_s;

  assign first   = (raw_cnt_r == 3'd0);
  assign raw_inc = (raw_cnt_r < RAW_SAT) ? raw_cnt_r + 3'd1 : raw_cnt_r;
  assign dec_byte = esc_r ? (beat.data_byte ^ ESC_XOR) : beat.data_byte;

  // frame state update
  always_comb begin
    raw_cnt_nxt    = raw_cnt_r;
    start_seen_nxt = start_seen_r;
    esc_nxt        = esc_r;
    dec_cnt_nxt    = dec_cnt_r;
    crc_nxt        = crc_r;
    older_nxt      = older_r;
    newer_nxt      = newer_r;
    type_nxt       = type_r;
    lat_nxt        = lat_r;
    lon_nxt        = lon_r;
    if (step) begin
      if (beat.last) begin
        raw_cnt_nxt    = '0;
        start_seen_nxt = 1'b0;
        esc_nxt        = 1'b0;
        dec_cnt_nxt    = '0;
        crc_nxt        = '0;
        older_nxt      = '0;
        newer_nxt      = '0;
        type_nxt       = '0;
        lat_nxt        = '0;
        lon_nxt        = '0;
      end else begin
        raw_cnt_nxt = raw_inc;
        if (first) begin
          start_seen_nxt = (beat.data_byte == FLAG_BYTE);
        end else if (beat.data_byte == ESC_BYTE) begin
          esc_nxt = 1'b1;
        end else begin
          esc_nxt = 1'b0;
          // decoded byte enters the hold-back; the oldest goes into the crc
          if (dec_cnt_r >= DCW'(2)) begin
            crc_nxt = crc_feed(crc_r, older_r);
          end
          older_nxt = newer_r;
          newer_nxt = dec_byte;
          if (dec_cnt_r == '0) begin
            type_nxt = dec_byte;
          end else if (dec_cnt_r >= DCW'(5) && dec_cnt_r <= DCW'(7)) begin
            lat_nxt = {lat_r[15:0], dec_byte};
          end else if (dec_cnt_r >= DCW'(8) && dec_cnt_r <= DCW'(10)) begin
            lon_nxt = {lon_r[15:0], dec_byte};
          end
          if (dec_cnt_r < DEC_SAT) begin
            dec_cnt_nxt = dec_cnt_r + DCW'(1);
          end
        end
      end
    end
  end

  // frame state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_cnt_r    <= '0;
      start_seen_r <= 1'b0;
      esc_r        <= 1'b0;
      dec_cnt_r    <= '0;
      crc_r        <= '0;
      older_r      <= '0;
      newer_r      <= '0;
      type_r       <= '0;
      lat_r        <= '0;
      lon_r        <= '0;
    end else begin
      raw_cnt_r    <= raw_cnt_nxt;
      start_seen_r <= start_seen_nxt;
      esc_r        <= esc_nxt;
      dec_cnt_r    <= dec_cnt_nxt;
      crc_r        <= crc_nxt;
      older_r      <= older_nxt;
      newer_r      <= newer_nxt;
      type_r       <= type_nxt;
      lat_r        <= lat_nxt;
      lon_r        <= lon_nxt;
    end
  end

  // end-of-frame result, valid on the closing beat
  assign plen     = (dec_cnt_r >= DCW'(2)) ? dec_cnt_r - DCW'(2) : '0;
  assign rx_crc   = {newer_r, older_r};
  assign start_ok = first ? (beat.data_byte == FLAG_BYTE) : start_seen_r;
  assign lat_s    = $signed(lat_r);

  always_comb begin
    result = '0;
    if (!start_ok) begin
      result.status = ST_BAD_START;
    end else if (beat.data_byte != FLAG_BYTE) begin
      result.status = ST_BAD_END;
    end else if (raw_inc < RAW_SAT || dec_cnt_r < DCW'(3)) begin
      result.status = ST_TOO_SHORT;
    end else if (esc_r) begin
      result.status = ST_DANGLE_ESC;
    end else if (crc_check_enable && crc_r != rx_crc) begin
      result.status = ST_CRC_ERR;
    end else begin
      result.status = ST_OK;
    end

    if (result.status == ST_OK || result.status == ST_CRC_ERR) begin
      result.message_id     = type_r;
      result.payload_length = 10'(plen);
      result.crc_computed   = crc_r;
      result.crc_received   = rx_crc;
    end
    if (result.status == ST_OK) begin
      result.is_heartbeat = (type_r == 8'd0);
      if (type_r == OWNSHIP_ID) begin
        result.ownship_length_ok = (plen == DCW'(28));
        if (plen >= DCW'(11)) begin
          result.position_valid = (lat_s >= -LAT_LIMIT) && (lat_s <= LAT_LIMIT);
          result.latitude_raw   = lat_s;
          result.longitude_raw  = $signed(lon_r);
        end
      end
    end
  end

endmodule

/* src/gdl90_frame_receiver_unit.sv */
// ----------------------------------------------------------------------------
// gdl90_frame_receiver_unit
// Byte-serial GDL90 frame receiver: flags, de-escaping, CRC-16 check and
// end-of-frame report with heartbeat and ownship position fields.
// ----------------------------------------------------------------------------
// result path: the closing byte passes the input register, then its result is
//   built into the result register and offered from there
// throughput: one byte per cycle while the result channel is not stalled
// reset: rst_n synchronous; clears frame state and both registers' valid,
//   crc_check_enable returns to 1
module gdl90_frame_receiver_unit #(
  parameter int MAX_FRAME_BYTES = 512
) (
  input  logic      clk,
  input  logic      rst_n,
  gfr_in_if.sink    in_ch,
  gfr_out_if.source out_ch,
  gfr_cfg_if.sink   cfg_ch
);
  import gfr_pkg::*;

  gfr_beat_t   s1_r, s1_nxt;
  logic        s1_valid_r, s1_valid_nxt;
  gfr_result_t out_r, out_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        crc_en_r, crc_en_nxt;

  logic        in_fire;
  logic        s1_adv;
  gfr_result_t core_res;

  // handshake
  assign s1_adv    = s1_valid_r && (!s1_r.last || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_fire   = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // next values
  always_comb begin
    s1_nxt        = s1_r;
    s1_valid_nxt  = s1_valid_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    crc_en_nxt    = crc_en_r;
    if (in_fire) begin
      s1_nxt.data_byte = in_ch.data_byte;
      s1_nxt.last      = in_ch.last;
      s1_valid_nxt     = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    if (s1_adv && s1_r.last) begin
      out_nxt       = core_res;
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cfg_ch.valid) begin
      crc_en_nxt = cfg_ch.crc_check_enable;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      crc_en_r    <= 1'b1;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      crc_en_r    <= crc_en_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    s1_r  <= s1_nxt;
    out_r <= out_nxt;
  end

  // frame decoder
  gfr_frame_core #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .step             (s1_adv),
    .beat             (s1_r),
    .crc_check_enable (crc_en_r),
    .result           (core_res)
  );

  // result channel
  assign out_ch.valid             = out_valid_r;
  assign out_ch.status            = out_r.status;
  assign out_ch.message_id        = out_r.message_id;
  assign out_ch.payload_length    = out_r.payload_length;
  assign out_ch.crc_computed      = out_r.crc_computed;
  assign out_ch.crc_received      = out_r.crc_received;
  assign out_ch.is_heartbeat      = out_r.is_heartbeat;
  assign out_ch.position_valid    = out_r.position_valid;
  assign out_ch.ownship_length_ok = out_r.ownship_length_ok;
  assign out_ch.latitude_raw      = out_r.latitude_raw;
  assign out_ch.longitude_raw     = out_r.longitude_raw;

endmodule
